### rtl/rc4_stream_cipher_core_assert.svh
// Assertion macros for the RC4 core checker.
// Used by rc4_core_chk; needs clk and rst_n in the calling scope.
`ifndef RC4_STREAM_CIPHER_CORE_ASSERT_SVH
`define RC4_STREAM_CIPHER_CORE_ASSERT_SVH

// Implication checked from the same edge, muted while reset is low.
`define RC4_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked from the next edge, muted while reset is low.
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication checked from the next edge, also live during reset.
`define RC4_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rc4_pkg.sv
// Shared constants and types of the RC4 core.
// No dependencies; used by the interfaces, engine and top level.
`default_nettype none

package rc4_pkg;

  localparam int KEY_BYTES  = 24;
  localparam int KEY_LEN_W  = 5;
  localparam int KEY_POS_W  = $clog2(KEY_BYTES);
  localparam int CFG_ADDR_W = 3;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;
  localparam logic [KEY_POS_W-1:0] KEY_POS_MAX   = 5'(KEY_BYTES - 1);

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_LOW  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_MID  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_HIGH = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_LEN  = 3'd3;

  // item opcodes
  localparam logic OP_KEY_SCHED = 1'b0;
  localparam logic OP_CRYPT     = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
    logic       last_in;
  } rc4_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
  } rc4_res_t;

  // engine <-> key store
  typedef struct packed {
    logic [KEY_POS_W-1:0] pos;
  } rc4_key_req_t;

  typedef struct packed {
    logic [7:0]           key_byte;
    logic [KEY_POS_W-1:0] key_last;
  } rc4_key_rsp_t;

endpackage

`default_nettype wire

### rtl/rc4_stream_if.sv
// Valid/ready channel interfaces of the RC4 core: input items, result items
// and configuration writes. Depends on rc4_pkg.
`default_nettype none

interface rc4_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;
  logic       last_in;

  modport source (output valid, output opcode, output data_byte, output last_in,
                  input ready);
  modport sink (input valid, input opcode, input data_byte, input last_in,
                output ready);
endinterface

interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_out;

  modport source (output valid, output out_byte, output last_out, input ready);
  modport sink (input valid, input out_byte, input last_out, output ready);
endinterface

interface rc4_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rc4_pkg::CFG_ADDR_W-1:0] addr;
  logic [63:0]                    wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

### rtl/rc4_engine.sv
// RC4 sequencer: permutation memory, index registers and one shared adder.
// Runs the key schedule and the per-byte keystream step. Depends on rc4_pkg.
`default_nettype none

module rc4_engine (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  item_valid,
  output logic                       item_ready,
  input  wire rc4_pkg::rc4_item_t    item,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output rc4_pkg::rc4_res_t          res,
  output rc4_pkg::rc4_key_req_t      key_req,
  input  wire rc4_pkg::rc4_key_rsp_t key_rsp
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_INIT     = 4'd1;
  localparam logic [3:0] ST_KS_RD_T  = 4'd2;
  localparam logic [3:0] ST_KS_RD_J  = 4'd3;
  localparam logic [3:0] ST_KS_WR_T  = 4'd4;
  localparam logic [3:0] ST_KS_WR_J  = 4'd5;
  localparam logic [3:0] ST_CR_RD_I  = 4'd6;
  localparam logic [3:0] ST_CR_RD_J  = 4'd7;
  localparam logic [3:0] ST_CR_WR_I  = 4'd8;
  localparam logic [3:0] ST_CR_WR_J  = 4'd9;
  localparam logic [3:0] ST_CR_RD_K  = 4'd10;
  localparam logic [3:0] ST_CR_OUT   = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [7:0] t_r, t_nxt;
  logic [7:0] i_r, i_nxt;
  logic [7:0] j_r, j_nxt;
  logic [rc4_pkg::KEY_POS_W-1:0] pos_r, pos_nxt;
  logic [7:0] si_r, si_nxt;
  logic [7:0] sj_r, sj_nxt;
  rc4_pkg::rc4_item_t item_r, item_nxt;

  // permutation memory
  logic [7:0] mem [256];
  logic       mem_we;
  logic [7:0] mem_waddr;
  logic [7:0] mem_wdata;
  logic [7:0] mem_raddr;
  logic [7:0] rdata_r;

  // shared adder
  logic [7:0] add_a, add_b, add_c;
  logic [9:0] add_full;
  logic [7:0] add_sum;

  assign add_full = {2'b00, add_a} + {2'b00, add_b} + {2'b00, add_c};
  assign add_sum  = add_full[7:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  assign key_req.pos   = pos_r;
  assign item_ready    = (state_r == ST_IDLE);
  assign res_valid     = (state_r == ST_CR_OUT);
  assign res.out_byte  = item_r.data_byte ^ rdata_r;
  assign res.last_out  = item_r.last_in;

  always_comb begin
    state_nxt = state_r;
    t_nxt     = t_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    pos_nxt   = pos_r;
    si_nxt    = si_r;
    sj_nxt    = sj_r;
    item_nxt  = item_r;
    mem_we    = 1'b0;
    mem_waddr = t_r;
    mem_wdata = t_r;
    mem_raddr = t_r;
    add_a     = j_r;
    add_b     = rdata_r;
    add_c     = 8'd0;

    unique case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          item_nxt = item;
          if (item.opcode == rc4_pkg::OP_KEY_SCHED) begin
            t_nxt     = 8'd0;
            state_nxt = ST_INIT;
          end else begin
            i_nxt     = i_r + 8'd1;
            state_nxt = ST_CR_RD_I;
          end
        end
      end
      ST_INIT: begin
        // load identity, one entry a cycle
        mem_we = 1'b1;
        t_nxt  = t_r + 8'd1;
        if (t_r == 8'hff) begin
          j_nxt     = 8'd0;
          pos_nxt   = '0;
          state_nxt = ST_KS_RD_T;
        end
      end
      ST_KS_RD_T: begin
        state_nxt = ST_KS_RD_J;
      end
      ST_KS_RD_J: begin
        add_c     = key_rsp.key_byte;
        si_nxt    = rdata_r;
        j_nxt     = add_sum;
        mem_raddr = add_sum;
        pos_nxt   = (pos_r == key_rsp.key_last) ? '0 : pos_r + 5'd1;
        state_nxt = ST_KS_WR_T;
      end
      ST_KS_WR_T: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_r;
        state_nxt = ST_KS_WR_J;
      end
      ST_KS_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = si_r;
        t_nxt     = t_r + 8'd1;
        if (t_r == 8'hff) begin
          i_nxt     = 8'd0;
          j_nxt     = 8'd0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_KS_RD_T;
        end
      end
      ST_CR_RD_I: begin
        mem_raddr = i_r;
        state_nxt = ST_CR_RD_J;
      end
      ST_CR_RD_J: begin
        si_nxt    = rdata_r;
        j_nxt     = add_sum;
        mem_raddr = add_sum;
        state_nxt = ST_CR_WR_I;
      end
      ST_CR_WR_I: begin
        sj_nxt    = rdata_r;
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = rdata_r;
        state_nxt = ST_CR_WR_J;
      end
      ST_CR_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = si_r;
        state_nxt = ST_CR_RD_K;
      end
      ST_CR_RD_K, ST_CR_OUT: begin
        // keep the keystream address on the port so the read data holds
        add_a     = si_r;
        add_b     = sj_r;
        mem_raddr = add_sum;
        if (state_r == ST_CR_RD_K) begin
          state_nxt = ST_CR_OUT;
        end else if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      t_r     <= 8'd0;
      i_r     <= 8'd0;
      j_r     <= 8'd0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      t_r     <= t_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r   <= si_nxt;
    sj_r   <= sj_nxt;
    item_r <= item_nxt;
  end

endmodule

`default_nettype wire

### rtl/rc4_stream_cipher_core.sv
// RC4 stream cipher core.
// Channels: in_ch takes items (opcode, data_byte, last_in), out_ch returns
// result items (out_byte, last_out), cfg_ch writes the key registers
// (index 0..2 key words low/mid/high, index 3 key length); cfg_ch is always
// ready, write it only while the core is idle.
// A key-schedule item (opcode 0) loads the permutation with the identity and
// runs 256 swap steps (read S[t], read S[j], write both): in_ready stays low
// until it is done and no result item is produced. It clears both indices.
// A crypt item (opcode 1) is one walk of the sequencer through the single
// read port and single write port of the 256x8 permutation memory (states
// RD_I, RD_J, WR_I, WR_J, RD_K, OUT); the result enters the output register
// as it leaves OUT, and in_ready returns at that same edge, not before.
// Crypt items before the first key schedule return undefined bytes.
// Reset (rst_n low, synchronous) clears indices, empties the output register
// and sets the key to zero with length 16; the permutation is not cleared.
// When out_ch stalls, the finished result holds in the output register; the
// core takes one more item and parks its result until the register frees.
// Depends on rc4_pkg, rc4_stream_if and rc4_engine.
`default_nettype none

module rc4_stream_cipher_core (
  input  wire logic clk,
  input  wire logic rst_n,
  rc4_in_if.sink    in_ch,
  rc4_out_if.source out_ch,
  rc4_cfg_if.sink   cfg_ch
);

  logic [63:0]                   key_low_r, key_mid_r, key_high_r;
  logic [rc4_pkg::KEY_LEN_W-1:0] key_len_r;

  logic [rc4_pkg::KEY_BYTES-1:0][7:0] key_bytes;

  rc4_pkg::rc4_item_t    item;
  rc4_pkg::rc4_res_t     res;
  rc4_pkg::rc4_res_t     out_r;
  logic                  res_valid, res_ready;
  logic                  out_valid_r;
  rc4_pkg::rc4_key_req_t key_req;
  rc4_pkg::rc4_key_rsp_t key_rsp;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= 64'd0;
      key_mid_r  <= 64'd0;
      key_high_r <= 64'd0;
      key_len_r  <= rc4_pkg::KEY_LEN_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        rc4_pkg::CFG_KEY_LOW:  key_low_r  <= cfg_ch.wdata;
        rc4_pkg::CFG_KEY_MID:  key_mid_r  <= cfg_ch.wdata;
        rc4_pkg::CFG_KEY_HIGH: key_high_r <= cfg_ch.wdata;
        rc4_pkg::CFG_KEY_LEN:  key_len_r  <= cfg_ch.wdata[rc4_pkg::KEY_LEN_W-1:0];
        default: ; // drop writes past the register list
      endcase
    end
  end

  assign key_bytes = {key_high_r, key_mid_r, key_low_r};

  // saturate length to 1..24, hand over the wrap position
  always_comb begin
    key_rsp.key_byte = key_bytes[key_req.pos];
    if (key_len_r == '0) begin
      key_rsp.key_last = '0;
    end else if (key_len_r > 5'(rc4_pkg::KEY_BYTES)) begin
      key_rsp.key_last = rc4_pkg::KEY_POS_MAX;
    end else begin
      key_rsp.key_last = key_len_r - 5'd1;
    end
  end

  assign item.opcode    = in_ch.opcode;
  assign item.data_byte = in_ch.data_byte;
  assign item.last_in   = in_ch.last_in;

  rc4_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_ch.valid),
    .item_ready (in_ch.ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .key_req    (key_req),
    .key_rsp    (key_rsp)
  );

  // output register
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_r.out_byte;
  assign out_ch.last_out = out_r.last_out;

endmodule

`default_nettype wire

### rtl/rc4_core_chk.sv
// Port-level checker for rc4_stream_cipher_core and its bind statement.
// Depends on rc4_pkg and rc4_stream_cipher_core_assert.svh.
`default_nettype none
`include "rc4_stream_cipher_core_assert.svh"

module rc4_core_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_opcode,
  input wire logic out_valid,
  input wire logic out_ready
);

  `RC4_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid,
                   "result item dropped while stalled")
  `RC4_ASSERT_ALWAYS(a_out_reset, !rst_n, !out_valid,
                     "result valid right after reset")
  `RC4_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
                   "ready right after an item")
  `RC4_ASSERT_SAME(a_ks_busy,
                   in_valid && in_ready && in_opcode == rc4_pkg::OP_KEY_SCHED,
                   ##8 !in_ready, "key schedule ended early")

endmodule

bind rc4_stream_cipher_core rc4_core_chk u_rc4_core_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_opcode (in_ch.opcode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

`default_nettype wire

### sim/rc4_stream_cipher_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for rc4_stream_cipher_core: drives key writes, key schedules
// and crypt bytes, and checks every result byte against a keystream tracker.
// Depends on rc4_pkg, rc4_stream_if and the RTL of the core.

module rc4_stream_cipher_core_tb;

  localparam int ITEM_TARGET = 1100;
  localparam int SCHED_TAIL  = 1400;  // long enough to wait out a key schedule
  localparam int QUIET_LIMIT = 10000;

  // Tracks key registers, permutation and indices; queues the bytes the core owes us.
  class rc4_cipher_tracker;
    logic [63:0]       key_words [3];
    logic [4:0]        key_len;
    logic [7:0]        perm [256];
    logic [7:0]        idx_i;
    logic [7:0]        idx_j;
    rc4_pkg::rc4_res_t pending_bytes [$];
    int                mismatches;

    function new();
      key_words[0] = '0;
      key_words[1] = '0;
      key_words[2] = '0;
      key_len      = rc4_pkg::KEY_LEN_RESET;
      idx_i        = '0;
      idx_j        = '0;
      mismatches   = 0;
      for (int t = 0; t < 256; t++) perm[t] = '0;
    endfunction

    function void write_reg(logic [rc4_pkg::CFG_ADDR_W-1:0] addr, logic [63:0] value);
      case (addr)
        rc4_pkg::CFG_KEY_LOW:  key_words[0] = value;
        rc4_pkg::CFG_KEY_MID:  key_words[1] = value;
        rc4_pkg::CFG_KEY_HIGH: key_words[2] = value;
        rc4_pkg::CFG_KEY_LEN:  key_len = value[rc4_pkg::KEY_LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(rc4_pkg::rc4_item_t it);
      int                n;
      int                pos;
      logic [7:0]        jj;
      logic [7:0]        a;
      logic [7:0]        b;
      logic [7:0]        sum;
      rc4_pkg::rc4_res_t res;
      if (it.opcode == rc4_pkg::OP_KEY_SCHED) begin
        // saturate the length into 1..24, then run the standard schedule
        n = key_len;
        if (n == 0) n = 1;
        if (n > rc4_pkg::KEY_BYTES) n = rc4_pkg::KEY_BYTES;
        for (int t = 0; t < 256; t++) perm[t] = t[7:0];
        jj  = '0;
        pos = 0;
        for (int t = 0; t < 256; t++) begin
          jj = jj + perm[t] + key_words[pos / 8][8 * (pos % 8) +: 8];
          a = perm[t];
          perm[t] = perm[jj];
          perm[jj] = a;
          pos++;
          if (pos >= n) pos = 0;
        end
        idx_i = '0;
        idx_j = '0;
      end else begin
        idx_i = idx_i + 8'd1;
        idx_j = idx_j + perm[idx_i];
        a = perm[idx_i];
        b = perm[idx_j];
        perm[idx_i] = b;
        perm[idx_j] = a;
        sum = a + b;
        res.out_byte = it.data_byte ^ perm[sum];
        res.last_out = it.last_in;
        pending_bytes.push_back(res);
      end
    endfunction

    function void check_result(rc4_pkg::rc4_res_t got);
      rc4_pkg::rc4_res_t want;
      if (pending_bytes.size() == 0) begin
        $error("unexpected result: out_byte %02h last_out %0b", got.out_byte, got.last_out);
        mismatches++;
        return;
      end
      want = pending_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.last_out !== want.last_out) begin
        $error("last_out: expected %0b, got %0b", want.last_out, got.last_out);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_bytes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;
  int   in_gap_pct;
  int   items_sent;
  int   quiet_cycles;
  rc4_cipher_tracker tracker;

  rc4_in_if  in_bus ();
  rc4_out_if out_bus ();
  rc4_cfg_if cfg_bus ();

  rc4_stream_cipher_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always #5 clk = ~clk;

  // Observe all three channels at the rising edge; also the stall watchdog.
  always @(posedge clk) begin : monitor
    bit                 hit;
    rc4_pkg::rc4_item_t got_item;
    rc4_pkg::rc4_res_t  got_res;
    if (rst_n) begin
      hit = 1'b0;
      if (cfg_bus.valid && cfg_bus.ready) begin
        tracker.write_reg(cfg_bus.addr, cfg_bus.wdata);
        hit = 1'b1;
      end
      if (in_bus.valid && in_bus.ready) begin
        got_item.opcode    = in_bus.opcode;
        got_item.data_byte = in_bus.data_byte;
        got_item.last_in   = in_bus.last_in;
        tracker.note_item(got_item);
        hit = 1'b1;
      end
      if (out_bus.valid && out_bus.ready) begin
        got_res.out_byte = out_bus.out_byte;
        got_res.last_out = out_bus.last_out;
        tracker.check_result(got_res);
        hit = 1'b1;
      end
      quiet_cycles = hit ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[rc4_stream_cipher_core] ERROR");
        $finish;
      end
    end
  end

  // Result side: stretches of random stall bursts, some stretches with none.
  initial begin : result_sink
    int stall_pct;
    int left;
    int burst;
    out_bus.ready <= 1'b0;
    forever begin
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 10;
        default: stall_pct = 35;
      endcase
      left = $urandom_range(100, 400);
      while (left > 0) begin
        @(negedge clk);
        if (!calm && $urandom_range(0, 99) < stall_pct) begin
          burst = $urandom_range(1, 19);
          out_bus.ready <= 1'b0;
          repeat (burst - 1) @(negedge clk);
          left -= burst;
        end else begin
          out_bus.ready <= 1'b1;
          left--;
        end
      end
    end
  end

  task automatic send_item(input logic op, input logic [7:0] data, input logic last_flag);
    if (!calm && $urandom_range(0, 99) < in_gap_pct) begin
      repeat ($urandom_range(1, 19)) begin
        @(negedge clk);
        in_bus.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_bus.valid     <= 1'b1;
    in_bus.opcode    <= op;
    in_bus.data_byte <= data;
    in_bus.last_in   <= last_flag;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
  endtask

  task automatic send_crypt(input logic [7:0] data, input logic last_flag);
    send_item(rc4_pkg::OP_CRYPT, data, last_flag);
  endtask

  // Key schedule ignores data and last, so fill them with noise.
  task automatic send_rekey();
    send_item(rc4_pkg::OP_KEY_SCHED, 8'($urandom), 1'($urandom));
  endtask

  // Hold the input side until every owed byte is back, then wait out the tail (with SCHED_TAIL, any schedule).
  task automatic drain(input int tail);
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rc4_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [63:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr  <= addr;
    cfg_bus.wdata <= value;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  task automatic program_key(input logic [63:0] lo, input logic [63:0] mid,
                             input logic [63:0] hi, input logic [63:0] len_word,
                             input bit poke_unused);
    if (poke_unused) begin
      for (int k = 1; k <= 4; k++) begin
        write_reg(rc4_pkg::CFG_KEY_LEN + k[rc4_pkg::CFG_ADDR_W-1:0], {$urandom, $urandom});
      end
    end
    write_reg(rc4_pkg::CFG_KEY_LOW, lo);
    write_reg(rc4_pkg::CFG_KEY_MID, mid);
    write_reg(rc4_pkg::CFG_KEY_HIGH, hi);
    write_reg(rc4_pkg::CFG_KEY_LEN, len_word);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [63:0] len_word(input logic [4:0] len);
    logic [63:0] w;
    w = {$urandom, $urandom};
    w[rc4_pkg::KEY_LEN_W-1:0] = len;
    return w;
  endfunction

  initial begin : stimulus
    int count;
    int r;
    logic [4:0] len;
    tracker          = new();
    calm             = 1'b0;
    in_gap_pct       = 0;
    items_sent       = 0;
    quiet_cycles     = 0;
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.opcode    <= rc4_pkg::OP_KEY_SCHED;
    in_bus.data_byte <= '0;
    in_bus.last_in   <= 1'b0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.addr     <= rc4_pkg::CFG_KEY_LOW;
    cfg_bus.wdata    <= '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset key: sixteen zero bytes
    send_item(rc4_pkg::OP_KEY_SCHED, 8'hff, 1'b1);
    send_crypt(8'h00, 1'b0);
    send_crypt(8'hff, 1'b1);

    drain(SCHED_TAIL);
    program_key('1, '1, '1, len_word(5'd24), 1'b0);
    send_item(rc4_pkg::OP_KEY_SCHED, 8'h00, 1'b0);
    send_crypt(8'h00, 1'b0);
    send_crypt(8'hff, 1'b0);
    send_crypt(8'ha5, 1'b1);

    // zero length saturates up to one byte; unused indexes must be ignored
    drain(SCHED_TAIL);
    in_gap_pct = 30;
    program_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                len_word(5'd0), 1'b1);
    send_rekey();
    send_crypt(8'h5a, 1'b0);
    send_crypt(8'h01, 1'b1);

    // oversize length saturates down to 24
    drain(SCHED_TAIL);
    program_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                len_word(5'd31), 1'b0);
    send_rekey();
    send_crypt(8'h80, 1'b0);
    send_crypt(8'h7f, 1'b1);

    // one zero key byte; a second schedule restarts the keystream
    drain(SCHED_TAIL);
    program_key('0, '0, '0, len_word(5'd1), 1'b0);
    send_rekey();
    send_crypt(8'h00, 1'b0);
    send_crypt(8'h00, 1'b1);
    send_rekey();
    send_crypt(8'h00, 1'b0);
    send_crypt(8'h00, 1'b1);

    // new key without a schedule keeps the old table running
    drain(SCHED_TAIL);
    program_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                len_word(5'd25), 1'b0);
    send_crypt(8'hc3, 1'b0);
    send_crypt(8'h3c, 1'b1);
    send_rekey();
    send_crypt(8'h11, 1'b1);

    for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
      drain(SCHED_TAIL);
      if (items_sent > ITEM_TARGET - 150) calm = 1'b1;
      case ($urandom_range(0, 2))
        0: in_gap_pct = 0;
        1: in_gap_pct = 10;
        default: in_gap_pct = 40;
      endcase
      r   = $urandom_range(0, 9);
      len = (r < 8) ? 5'($urandom_range(1, rc4_pkg::KEY_BYTES)) : 5'($urandom_range(0, 31));
      program_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  len_word(len), $urandom_range(0, 7) == 0);
      if ($urandom_range(0, 7) != 0) send_rekey();
      count = $urandom_range(40, 120);
      for (int k = 0; k < count; k++) begin
        if (phase == 1 && k == count / 2) drain(0);
        if ($urandom_range(0, 79) == 0) send_rekey();
        else send_crypt(8'($urandom), $urandom_range(0, 15) == 0);
      end
    end

    drain(SCHED_TAIL);
    if (tracker.mismatches == 0) begin
      $display("[rc4_stream_cipher_core] OK");
    end else begin
      $display("[rc4_stream_cipher_core] ERROR");
    end
    $finish;
  end

endmodule
